FILE: rtl/i2cmts_pkg.sv
package i2cmts_pkg;

  // Host command or bus event carried by one input transaction
  typedef enum logic [2:0] {
    ACT_BEGIN_WRITE = 3'd0,
    ACT_QUEUE_BYTE  = 3'd1,
    ACT_END_WRITE   = 3'd2,
    ACT_REQ_READ    = 3'd3,
    ACT_BUS_EVENT   = 3'd4,
    ACT_POP         = 3'd5,
    ACT_PEEK        = 3'd6,
    ACT_FLUSH       = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_NOT_TX    = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_NO_XFER   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BC_NONE      = 3'd0,
    BC_SEND_ADDR = 3'd1,
    BC_SEND_DATA = 3'd2,
    BC_ACK_RECV  = 3'd3,
    BC_STOP      = 3'd4,
    BC_NACK_STOP = 3'd5,
    BC_CLR_ARB   = 3'd6,
    BC_CLR_FAULT = 3'd7
  } bus_cmd_e;

  typedef enum logic [1:0] {
    RES_SUCCESS  = 2'd0,
    RES_NACK     = 2'd1,
    RES_ARB_LOST = 2'd2,
    RES_BUS_ERR  = 2'd3
  } result_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  target_address;
    logic [7:0]  data_byte;
    logic [7:0]  read_count;
    logic        arb_lost;
    logic        bus_fault;
    logic        write_done;
    logic        read_done;
    logic        got_nack;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    bus_cmd_e    bus_command;
    logic [7:0]  bus_byte;
    logic [7:0]  read_data;
    logic        read_valid;
    result_e     transfer_result;
    logic [5:0]  rx_available;
    logic [5:0]  reads_pending;
  } out_item_t;

endpackage

FILE: rtl/i2cmts_cmd_if.sv
interface i2cmts_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] target_address;
  logic [7:0] data_byte;
  logic [7:0] read_count;
  logic       arb_lost;
  logic       bus_fault;
  logic       write_done;
  logic       read_done;
  logic       got_nack;
  logic [7:0] bus_data;

  modport source (
    output valid, action, target_address, data_byte, read_count,
           arb_lost, bus_fault, write_done, read_done, got_nack, bus_data,
    input  ready
  );

  modport sink (
    input  valid, action, target_address, data_byte, read_count,
           arb_lost, bus_fault, write_done, read_done, got_nack, bus_data,
    output ready
  );
endinterface

FILE: rtl/i2cmts_res_if.sv
interface i2cmts_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] bus_command;
  logic [7:0] bus_byte;
  logic [7:0] read_data;
  logic       read_valid;
  logic [1:0] transfer_result;
  logic [5:0] rx_available;
  logic [5:0] reads_pending;

  modport source (
    output valid, status, bus_command, bus_byte, read_data, read_valid,
           transfer_result, rx_available, reads_pending,
    input  ready
  );

  modport sink (
    input  valid, status, bus_command, bus_byte, read_data, read_valid,
           transfer_result, rx_available, reads_pending,
    output ready
  );
endinterface

FILE: rtl/i2c_master_transfer_sequencer_core.sv
// I2C master transfer sequencer. Each command transaction (begin write, queue
// byte, end write, request read, bus event, pop, peek, flush) yields exactly
// one result transaction carrying status, the next bus command and byte, a
// popped/peeked receive byte, the sticky transfer result and the receive and
// pending-read counts. Throughput is one transaction per clock unless res_o.ready
// stalls it; a command passes the command register, then the result register,
// which lets a new command enter while an earlier result still waits on res_o.ready.
// Each byte store (transmit and receive, BUFFER_DEPTH bytes each) is a
// single-write, single-read memory whose registered read port is steered by
// the next read pointer, so the byte at the current pointer is always ready.
// Stores need no clearing after reset: they are only read below their fill
// marks. Counts above 63 show modulo 64 on rx_available and reads_pending.
module i2c_master_transfer_sequencer_core
  import i2cmts_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32   // 1..256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cmts_cmd_if.sink   cmd_i,
  i2cmts_res_if.source res_o
);

  localparam int CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int IdxW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [CntW-1:0] DepthC  = CntW'(BUFFER_DEPTH);
  localparam logic [8:0]      Depth9  = 9'(BUFFER_DEPTH);
  localparam logic [CntW-1:0] OneC    = CntW'(1);

  // ---------------------------------------------------------------------
  // Handshake / pipeline control
  // ---------------------------------------------------------------------
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  out_item_t res_d;
  logic      out_free;
  logic      fire;

  assign out_free    = !out_vld_q || res_o.ready;
  assign fire        = in_vld_q && out_free;
  assign cmd_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q.action         <= action_e'(cmd_i.action);
      in_q.target_address <= cmd_i.target_address;
      in_q.data_byte      <= cmd_i.data_byte;
      in_q.read_count     <= cmd_i.read_count;
      in_q.arb_lost       <= cmd_i.arb_lost;
      in_q.bus_fault      <= cmd_i.bus_fault;
      in_q.write_done     <= cmd_i.write_done;
      in_q.read_done      <= cmd_i.read_done;
      in_q.got_nack       <= cmd_i.got_nack;
      in_q.bus_data       <= cmd_i.bus_data;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  logic [7:0]      addr_q, addr_d;
  logic [CntW-1:0] tx_fill_q, tx_fill_d;
  logic [CntW-1:0] tx_rd_q, tx_rd_d;
  logic [CntW-1:0] rx_fill_q, rx_fill_d;
  logic [CntW-1:0] rx_rd_q, rx_rd_d;
  logic [CntW-1:0] reads_left_q, reads_left_d;
  result_e         result_q, result_d;

  logic            tx_we, rx_we;
  logic [7:0]      tx_rdata_q, rx_rdata_q;
  logic            addr_ok;
  logic            rcount_big;

  // valid 7-bit address: 1..127
  assign addr_ok    = !in_q.target_address[7] && (|in_q.target_address);
  assign rcount_big = {1'b0, in_q.read_count} > Depth9;

  always_comb begin
    addr_d       = addr_q;
    tx_fill_d    = tx_fill_q;
    tx_rd_d      = tx_rd_q;
    rx_fill_d    = rx_fill_q;
    rx_rd_d      = rx_rd_q;
    reads_left_d = reads_left_q;
    result_d     = result_q;
    tx_we        = 1'b0;
    rx_we        = 1'b0;

    res_d.status      = ST_OK;
    res_d.bus_command = BC_NONE;
    res_d.bus_byte    = 8'h00;
    res_d.read_data   = 8'h00;
    res_d.read_valid  = 1'b0;

    if (fire) begin
      unique case (in_q.action) inside
        ACT_BEGIN_WRITE: begin
          if (!addr_ok) begin
            res_d.status = ST_BAD_ADDR;
          end else begin
            addr_d    = in_q.target_address;
            tx_fill_d = '0;
            tx_rd_d   = '0;
          end
        end
        ACT_QUEUE_BYTE: begin
          if (addr_q == 8'h00) begin
            res_d.status = ST_NOT_TX;
          end else if (tx_fill_q >= DepthC) begin
            res_d.status = ST_NO_ROOM;
          end else begin
            tx_we     = 1'b1;
            tx_fill_d = tx_fill_q + OneC;
          end
        end
        ACT_END_WRITE: begin
          if (addr_q == 8'h00) begin
            res_d.status = ST_NOT_TX;
          end else if (rcount_big) begin
            res_d.status = ST_NO_ROOM;
          end else begin
            tx_rd_d           = '0;
            rx_fill_d         = '0;
            rx_rd_d           = '0;
            reads_left_d      = CntW'(in_q.read_count);
            result_d          = RES_SUCCESS;
            addr_d            = {addr_q[6:0], 1'b0};  // write address, R/W=0
            res_d.bus_command = BC_SEND_ADDR;
            res_d.bus_byte    = {addr_q[6:0], 1'b0};
          end
        end
        ACT_REQ_READ: begin
          if (!addr_ok) begin
            res_d.status = ST_BAD_ADDR;
          end else if (in_q.read_count == 8'h00 || rcount_big) begin
            res_d.status = ST_NO_ROOM;
          end else begin
            tx_fill_d         = '0;
            tx_rd_d           = '0;
            rx_fill_d         = '0;
            rx_rd_d           = '0;
            reads_left_d      = CntW'(in_q.read_count);
            result_d          = RES_SUCCESS;
            addr_d            = {in_q.target_address[6:0], 1'b1};  // R/W=1
            res_d.bus_command = BC_SEND_ADDR;
            res_d.bus_byte    = {in_q.target_address[6:0], 1'b1};
          end
        end
        ACT_BUS_EVENT: begin
          // priority: arbitration lost, bus error, write done, read done
          if (in_q.arb_lost) begin
            res_d.bus_command = BC_CLR_ARB;
            result_d          = RES_ARB_LOST;
          end else if (in_q.bus_fault) begin
            res_d.bus_command = BC_CLR_FAULT;
            result_d          = RES_BUS_ERR;
          end else if (in_q.write_done) begin
            if (in_q.got_nack) begin
              res_d.bus_command = BC_STOP;
              result_d          = RES_NACK;
            end else if (tx_rd_q < tx_fill_q) begin
              res_d.bus_command = BC_SEND_DATA;
              res_d.bus_byte    = tx_rdata_q;
              tx_rd_d           = tx_rd_q + OneC;
            end else if (reads_left_q != '0) begin
              // repeated start into the read phase
              res_d.bus_command = BC_SEND_ADDR;
              res_d.bus_byte    = {addr_q[7:1], 1'b1};
            end else begin
              res_d.bus_command = BC_STOP;
              result_d          = RES_SUCCESS;
            end
          end else if (in_q.read_done) begin
            if (reads_left_q != '0) begin
              // byte beyond store depth is dropped but still counted
              if (rx_fill_q < DepthC) begin
                rx_we     = 1'b1;
                rx_fill_d = rx_fill_q + OneC;
              end
              reads_left_d = reads_left_q - OneC;
            end
            if (reads_left_d != '0) begin
              res_d.bus_command = BC_ACK_RECV;
            end else begin
              res_d.bus_command = BC_NACK_STOP;
              result_d          = RES_SUCCESS;
            end
          end else begin
            res_d.status = ST_NO_XFER;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (rx_rd_q < rx_fill_q) begin
            res_d.read_data  = rx_rdata_q;
            res_d.read_valid = 1'b1;
            if (in_q.action == ACT_POP) begin
              rx_rd_d = rx_rd_q + OneC;
            end
          end else begin
            res_d.status = ST_EMPTY;
          end
        end
        ACT_FLUSH: begin
          rx_fill_d = '0;
          rx_rd_d   = '0;
        end
        default: begin
        end
      endcase
    end

    res_d.transfer_result = result_d;
    res_d.rx_available    = 6'(rx_fill_d - rx_rd_d);
    res_d.reads_pending   = 6'(reads_left_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= 8'h00;
      tx_fill_q    <= '0;
      tx_rd_q      <= '0;
      rx_fill_q    <= '0;
      rx_rd_q      <= '0;
      reads_left_q <= '0;
      result_q     <= RES_SUCCESS;
    end else begin
      addr_q       <= addr_d;
      tx_fill_q    <= tx_fill_d;
      tx_rd_q      <= tx_rd_d;
      rx_fill_q    <= rx_fill_d;
      rx_rd_q      <= rx_rd_d;
      reads_left_q <= reads_left_d;
      result_q     <= result_d;
    end
  end

  // ---------------------------------------------------------------------
  // Byte stores: one write port, one registered read port each. The read
  // register tracks the next pointer, with write-through on a collision.
  // ---------------------------------------------------------------------
  logic [7:0]      tx_mem [BUFFER_DEPTH];
  logic [7:0]      rx_mem [BUFFER_DEPTH];
  logic [IdxW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;

  assign tx_waddr = tx_fill_q[IdxW-1:0];
  assign tx_raddr = tx_rd_d[IdxW-1:0];
  assign rx_waddr = rx_fill_q[IdxW-1:0];
  assign rx_raddr = rx_rd_d[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= in_q.data_byte;
    end
    if (tx_we && tx_waddr == tx_raddr) begin
      tx_rdata_q <= in_q.data_byte;
    end else begin
      tx_rdata_q <= tx_mem[tx_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= in_q.bus_data;
    end
    if (rx_we && rx_waddr == rx_raddr) begin
      rx_rdata_q <= in_q.bus_data;
    end else begin
      rx_rdata_q <= rx_mem[rx_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.status          = out_q.status;
  assign res_o.bus_command     = out_q.bus_command;
  assign res_o.bus_byte        = out_q.bus_byte;
  assign res_o.read_data       = out_q.read_data;
  assign res_o.read_valid      = out_q.read_valid;
  assign res_o.transfer_result = out_q.transfer_result;
  assign res_o.rx_available    = out_q.rx_available;
  assign res_o.reads_pending   = out_q.reads_pending;

endmodule

FILE: rtl/i2cmts_checker.sv
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [2:0] status_i,
  input logic [2:0] bus_command_i,
  input logic [7:0] bus_byte_i,
  input logic [7:0] read_data_i,
  input logic       read_valid_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i) &&
      $stable(bus_command_i) && $stable(bus_byte_i) && $stable(read_data_i))
    else $error("result changed while stalled");

  // any error status issues no bus command
  a_err_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != ST_OK |-> bus_command_i == BC_NONE)
    else $error("bus command issued with error status");

  // receive byte only when marked valid, and then with ok status
  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (read_valid_i ? status_i == ST_OK : read_data_i == 8'h00))
    else $error("read data inconsistent with read_valid");

  // bus byte only rides with address or data commands
  a_bbyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && bus_byte_i != 8'h00 |->
      (bus_command_i == BC_SEND_ADDR || bus_command_i == BC_SEND_DATA))
    else $error("bus byte without send command");

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_i2cmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .bus_command_i (res_o.bus_command),
  .bus_byte_i    (res_o.bus_byte),
  .read_data_i   (res_o.read_data),
  .read_valid_i  (res_o.read_valid)
);

FILE: tb/i2c_master_transfer_sequencer_core_test.sv
`timescale 1ns / 100ps

// Transaction-level check of the I2C transfer sequencer.
// Every accepted command transaction runs through a local predictor, and the
// predicted result is queued. Each accepted result transaction must match the
// oldest queued prediction, field by field.
module i2c_master_transfer_sequencer_core_test;
  import i2cmts_pkg::*;

  localparam int DEPTH          = 32;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int RESET_CYCLES   = 6;
  localparam int N_ITEMS        = 850;
  localparam int HOLD_CYCLES    = 120;   // long sink hold-off, fills the pipeline
  localparam int DRAIN_CYCLES   = 10;    // command and result registers plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_RARE
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  i2cmts_cmd_if cmd ();
  i2cmts_res_if res ();

  i2c_master_transfer_sequencer_core #(
    .BUFFER_DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state, mirrors the block after reset
  // ---------------------------------------------------------------------------
  logic [7:0] addr_shadow = 8'h00;
  logic [7:0] tx_bytes [DEPTH];
  logic [7:0] rx_bytes [DEPTH];
  int         tx_count    = 0;
  int         tx_sent     = 0;
  int         rx_count    = 0;
  int         rx_taken    = 0;
  int         reads_owed  = 0;
  result_e    xfer_result = RES_SUCCESS;

  out_item_t  expected_results [$];
  int         items_sent  = 0;
  int         error_count = 0;

  // sender burst control
  int         burst_left  = 0;
  bit         gaps_on     = 1'b1;

  // sink control; hold_requests is bumped by the stimulus, served below
  logic       rx_ready      = 1'b0;
  int         hold_requests = 0;
  int         hold_seen     = 0;
  int         hold_left     = 0;
  int         mode_left     = 0;
  int         rx_phase      = 0;
  rx_mode_e   rx_mode       = RX_ALWAYS;

  int         idle_cycles   = 0;

  assign res.ready = rx_ready;

  // Next result of the sequencer for one command; updates the shadow state.
  function automatic out_item_t sequence_step(in_item_t c);
    out_item_t r;
    r = '0;
    case (c.action) inside
      ACT_BEGIN_WRITE: begin
        if (c.target_address == 8'd0 || c.target_address > 8'd127) begin
          r.status = ST_BAD_ADDR;
        end else begin
          addr_shadow = c.target_address;
          tx_count    = 0;
          tx_sent     = 0;
        end
      end
      ACT_QUEUE_BYTE: begin
        if (addr_shadow == 8'd0) begin
          r.status = ST_NOT_TX;
        end else if (tx_count >= DEPTH) begin
          r.status = ST_NO_ROOM;
        end else begin
          tx_bytes[IDX_W'(tx_count)] = c.data_byte;
          tx_count++;
        end
      end
      ACT_END_WRITE: begin
        if (addr_shadow == 8'd0) begin
          r.status = ST_NOT_TX;
        end else if (c.read_count > DEPTH) begin
          r.status = ST_NO_ROOM;
        end else begin
          tx_sent       = 0;
          rx_count      = 0;
          rx_taken      = 0;
          reads_owed    = int'(c.read_count);
          xfer_result   = RES_SUCCESS;
          addr_shadow   = addr_shadow << 1;   // wraps at 8 bits on a repeat
          r.bus_command = BC_SEND_ADDR;
          r.bus_byte    = addr_shadow;
        end
      end
      ACT_REQ_READ: begin
        if (c.target_address == 8'd0 || c.target_address > 8'd127) begin
          r.status = ST_BAD_ADDR;
        end else if (c.read_count == 8'd0 || c.read_count > DEPTH) begin
          r.status = ST_NO_ROOM;
        end else begin
          tx_count      = 0;
          tx_sent       = 0;
          rx_count      = 0;
          rx_taken      = 0;
          reads_owed    = int'(c.read_count);
          xfer_result   = RES_SUCCESS;
          addr_shadow   = {c.target_address[6:0], 1'b1};
          r.bus_command = BC_SEND_ADDR;
          r.bus_byte    = addr_shadow;
        end
      end
      ACT_BUS_EVENT: begin
        // arbitration beats bus fault beats write done beats read done
        if (c.arb_lost) begin
          r.bus_command = BC_CLR_ARB;
          xfer_result   = RES_ARB_LOST;
        end else if (c.bus_fault) begin
          r.bus_command = BC_CLR_FAULT;
          xfer_result   = RES_BUS_ERR;
        end else if (c.write_done) begin
          if (c.got_nack) begin
            r.bus_command = BC_STOP;
            xfer_result   = RES_NACK;
          end else if (tx_sent < tx_count) begin
            r.bus_command = BC_SEND_DATA;
            r.bus_byte    = tx_bytes[IDX_W'(tx_sent)];
            tx_sent++;
          end else if (reads_owed != 0) begin
            r.bus_command = BC_SEND_ADDR;   // repeated start for the read phase
            r.bus_byte    = addr_shadow | 8'h01;
          end else begin
            r.bus_command = BC_STOP;
            xfer_result   = RES_SUCCESS;
          end
        end else if (c.read_done) begin
          if (reads_owed != 0) begin
            if (rx_count < DEPTH) begin
              rx_bytes[IDX_W'(rx_count)] = c.bus_data;
              rx_count++;
            end
            reads_owed--;
          end
          if (reads_owed != 0) begin
            r.bus_command = BC_ACK_RECV;
          end else begin
            r.bus_command = BC_NACK_STOP;
            xfer_result   = RES_SUCCESS;
          end
        end else begin
          r.status = ST_NO_XFER;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (rx_taken < rx_count) begin
          r.read_data  = rx_bytes[IDX_W'(rx_taken)];
          r.read_valid = 1'b1;
          if (c.action == ACT_POP) rx_taken++;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_FLUSH: begin
        rx_count = 0;
        rx_taken = 0;
      end
    endcase
    r.transfer_result = xfer_result;
    r.rx_available    = 6'(rx_count - rx_taken);
    r.reads_pending   = 6'(reads_owed);
    return r;
  endfunction

  // Command with every field random except the action.
  function automatic in_item_t host_cmd(action_e a);
    in_item_t   c;
    logic [63:0] r;
    r = {$urandom, $urandom};
    c = r[$bits(in_item_t)-1:0];
    c.action = a;
    return c;
  endfunction

  function automatic in_item_t bus_event(logic arb, logic fault, logic wr, logic rd,
                                         logic nack);
    in_item_t c;
    c = host_cmd(ACT_BUS_EVENT);
    c.arb_lost   = arb;
    c.bus_fault  = fault;
    c.write_done = wr;
    c.read_done  = rd;
    c.got_nack   = nack;
    return c;
  endfunction

  // Offer one command transaction; inserts a random gap at the end of a burst.
  task automatic send(in_item_t c);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        cmd.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    cmd.valid          = 1'b1;
    cmd.action         = c.action;
    cmd.target_address = c.target_address;
    cmd.data_byte      = c.data_byte;
    cmd.read_count     = c.read_count;
    cmd.arb_lost       = c.arb_lost;
    cmd.bus_fault      = c.bus_fault;
    cmd.write_done     = c.write_done;
    cmd.read_done      = c.read_done;
    cmd.got_nack       = c.got_nack;
    cmd.bus_data       = c.bus_data;
    do begin
      @(posedge clk_i);
    end while (cmd.ready !== 1'b1);
    expected_results.push_back(sequence_step(c));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    cmd.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One step of a running transfer, now and then disturbed: a host command
  // slipped in, a lost arbitration, a bus fault or a NACK ends it early.
  task automatic transfer_event(input bit rx, output bit aborted);
    int pick;
    pick    = $urandom_range(0, 99);
    aborted = 1'b0;
    if (pick < 6) begin
      send(host_cmd(pick < 3 ? ACT_POP : ACT_PEEK));
    end else if (pick < 8) begin
      send(host_cmd(ACT_QUEUE_BYTE));
    end
    if (pick >= 97) begin
      send(bus_event(pick == 99, 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
      aborted = 1'b1;
    end else if (!rx && pick >= 94) begin
      send(bus_event(1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1));
      aborted = 1'b1;
    end else if (rx) begin
      send(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1))));
    end else begin
      send(bus_event(1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0));
    end
  endtask

  task automatic drain_rx(int n);
    repeat (n) send(host_cmd($urandom_range(0, 3) == 0 ? ACT_PEEK : ACT_POP));
    if ($urandom_range(0, 9) == 0) send(host_cmd(ACT_FLUSH));
  endtask

  task automatic write_transfer();
    in_item_t c;
    int       nbytes;
    int       rc;
    int       rc_eff;
    bit       ab;
    ab = 1'b0;
    c  = host_cmd(ACT_BEGIN_WRITE);
    c.target_address = 8'($urandom_range(1, 127));
    if ($urandom_range(0, 19) == 0) c.target_address[7] = 1'b1;
    send(c);
    nbytes = ($urandom_range(0, 11) == 0) ? $urandom_range(6, DEPTH + 2)
                                          : $urandom_range(0, 5);
    repeat (nbytes) send(host_cmd(ACT_QUEUE_BYTE));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: rc = 0;
      4, 5, 6, 7: rc = $urandom_range(1, 4);
      8:          rc = $urandom_range(5, DEPTH);
      default:    rc = $urandom_range(DEPTH + 1, 255);
    endcase
    c = host_cmd(ACT_END_WRITE);
    c.read_count = 8'(rc);
    send(c);
    rc_eff = (rc <= DEPTH) ? rc : 0;
    // address ack and each data byte, then stop or repeated start
    for (int i = 0; i <= ((nbytes < DEPTH) ? nbytes : DEPTH) && !ab; i++) begin
      transfer_event(1'b0, ab);
    end
    for (int i = 0; i < rc_eff && !ab; i++) transfer_event(1'b1, ab);
    drain_rx($urandom_range(0, rc_eff + 1));
  endtask

  task automatic read_transfer();
    in_item_t c;
    int       rc;
    bit       ab;
    ab = 1'b0;
    c  = host_cmd(ACT_REQ_READ);
    c.target_address = 8'($urandom_range(1, 127));
    if ($urandom_range(0, 19) == 0) c.target_address = 8'd0;
    case ($urandom_range(0, 14))
      0:       rc = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DEPTH + 1, 255);
      1:       rc = $urandom_range(7, DEPTH);
      default: rc = $urandom_range(1, 6);
    endcase
    c.read_count = 8'(rc);
    send(c);
    if (rc > DEPTH) rc = 0;
    for (int i = 0; i < rc && !ab; i++) transfer_event(1'b1, ab);
    drain_rx($urandom_range(0, rc + 1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    in_item_t c;
    send(host_cmd(ACT_PEEK));                        // empty receive store
    send(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));   // event with no flag
    send(host_cmd(ACT_QUEUE_BYTE));                  // nothing open yet
    send(host_cmd(ACT_END_WRITE));
    c = host_cmd(ACT_BEGIN_WRITE);
    c.target_address = 8'd0;
    send(c);
    c.target_address = 8'd128;
    send(c);
    c = host_cmd(ACT_REQ_READ);
    c.target_address = 8'd255;
    c.read_count     = 8'd1;
    send(c);
    c.target_address = 8'd127;
    c.read_count     = 8'd0;
    send(c);
    c.read_count     = 8'(DEPTH + 1);
    send(c);
    // write two bytes, then read two back with a repeated start
    c = host_cmd(ACT_BEGIN_WRITE);
    c.target_address = 8'd127;
    send(c);
    c = host_cmd(ACT_QUEUE_BYTE);
    c.data_byte = 8'h00;
    send(c);
    c.data_byte = 8'hFF;
    send(c);
    c = host_cmd(ACT_END_WRITE);
    c.read_count = 8'd255;
    send(c);
    c.read_count = 8'd2;
    send(c);
    repeat (3) send(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    c = bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    c.bus_data = 8'hA5;
    send(c);
    c.bus_data = 8'h5A;
    c.got_nack = 1'b1;
    send(c);
    repeat (3) send(host_cmd(ACT_POP));
    send(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));   // byte with no read pending
    send(bus_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));   // arbitration wins priority
    send(bus_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));   // fault over write/read done
    send(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));   // NACK on write
    send(host_cmd(ACT_FLUSH));
  endtask

  // Both byte stores at full depth, plus one over on the transmit side.
  task automatic test_store_limits();
    in_item_t c;
    c = host_cmd(ACT_BEGIN_WRITE);
    c.target_address = 8'h55;
    send(c);
    repeat (DEPTH + 1) send(host_cmd(ACT_QUEUE_BYTE));
    c = host_cmd(ACT_END_WRITE);
    c.read_count = 8'(DEPTH);
    send(c);
    repeat (DEPTH + 1) send(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    repeat (DEPTH) send(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1))));
    repeat (DEPTH + 1) send(host_cmd(ACT_POP));
    c = host_cmd(ACT_REQ_READ);
    c.target_address = 8'd1;
    c.read_count     = 8'(DEPTH);
    send(c);
    send(host_cmd(ACT_PEEK));
  endtask

  // Sink holds off while the source keeps offering back to back.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_requests++;
    repeat (3) write_transfer();
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (2) read_transfer();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int pick;
    while (items_sent < N_ITEMS) begin
      gaps_on = $urandom_range(0, 3) != 0;
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        write_transfer();
      end else if (pick < 80) begin
        read_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) send(host_cmd(action_e'($urandom_range(0, 7))));
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
      if ($urandom_range(0, 49) == 0) hold_requests++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink: own stall pattern, switching between modes, plus requested holds
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   rx_ready = 1'b1;
        RX_COIN:     rx_ready = 1'($urandom_range(0, 1));
        RX_PERIODIC: rx_ready = (rx_phase % 7) >= 3;
        default:     rx_ready = $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && res.valid === 1'b1 && res.ready === 1'b1) begin
      got = {res.status, res.bus_command, res.bus_byte, res.read_data, res.read_valid,
             res.transfer_result, res.rx_available, res.reads_pending};
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        report_field("status",          8'(want.status),          8'(got.status));
        report_field("bus_command",     8'(want.bus_command),     8'(got.bus_command));
        report_field("bus_byte",        want.bus_byte,            got.bus_byte);
        report_field("read_data",       want.read_data,           got.read_data);
        report_field("read_valid",      8'(want.read_valid),      8'(got.read_valid));
        report_field("transfer_result", 8'(want.transfer_result), 8'(got.transfer_result));
        report_field("rx_available",    8'(want.rx_available),    8'(got.rx_available));
        report_field("reads_pending",   8'(want.reads_pending),   8'(got.reads_pending));
      end
    end
  end

  // Watchdog: too long with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("i2c_master_transfer_sequencer_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    cmd.valid          = 1'b0;
    cmd.action         = ACT_FLUSH;
    cmd.target_address = 8'h00;
    cmd.data_byte      = 8'h00;
    cmd.read_count     = 8'h00;
    cmd.arb_lost       = 1'b0;
    cmd.bus_fault      = 1'b0;
    cmd.write_done     = 1'b0;
    cmd.read_done      = 1'b0;
    cmd.got_nack       = 1'b0;
    cmd.bus_data       = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_store_limits();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("i2c_master_transfer_sequencer_core_test: PASS");
    end else begin
      $display("i2c_master_transfer_sequencer_core_test: FAIL");
    end
    $finish;
  end

endmodule
